// File: sv/ipv4_source_byte_accounting_assert.svh
// Assertion macros shared by the accounting block.
`ifndef IPV4_SOURCE_BYTE_ACCOUNTING_ASSERT_SVH
`define IPV4_SOURCE_BYTE_ACCOUNTING_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define SBA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ipv4sba_pkg.sv
// Shared constants, types and codes for the source byte accounting block.
`timescale 1ns / 1ps
package ipv4sba_pkg;
   localparam int TABLE_ENTRIES = 1024;
   localparam int ADDR_W = $clog2(TABLE_ENTRIES);
   localparam int COUNT_W = ADDR_W + 1;
   localparam int LIMIT_W = 11;
   localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = LIMIT_W'(1000);
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] LAST_SHORT_POS = 16'd33;

   localparam logic [1:0] STATUS_COUNTED = 2'd0;
   localparam logic [1:0] STATUS_SKIPPED = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMPARE,
      ST_ACCUM
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load_job;
      logic report_skip;
      logic report_full;
      logic insert;
      logic step;
      logic accumulate;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_ok;
      logic scan_end;
      logic table_full;
      logic key_hit;
   } stat_type;
endpackage

// File: sv/ipv4sba_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ipv4sba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read of the same address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/ipv4sba_dp.sv
// Datapath: header capture, source table, counters and result registers.
`timescale 1ns / 1ps
module ipv4sba_dp
   import ipv4sba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [7:0]         req_packet_byte,
   input  logic               req_last_byte,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_entry_limit,
   output logic               rsp_strobe,
   output logic               rsp_accounted,
   output logic [31:0]        rsp_source_address,
   output logic [63:0]        rsp_byte_total,
   output logic [1:0]         rsp_frame_status
);
   logic [LIMIT_W-1:0] limit_ff;
   logic [15:0]        pos_ff, pos_in;
   logic [15:0]        ether_ff, ether_in;
   logic [15:0]        length_ff, length_in;
   logic [31:0]        source_ff, source_in;
   logic [31:0]        job_key_ff;
   logic [15:0]        job_len_ff;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               strobe_ff;
   logic               acc_ff;
   logic [31:0]        addr_out_ff;
   logic [63:0]        total_ff;
   logic [1:0]         fstat_ff;
   logic [31:0]        key_rdata;
   logic [63:0]        cnt_rdata;
   logic [63:0]        cnt_wdata;
   logic [63:0]        sum;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ENTRY_LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_entry_limit;
      end
   end

   // Header capture for each accepted beat; cleared at the frame's end.
   always_comb begin
      pos_in = pos_ff;
      ether_in = ether_ff;
      length_in = length_ff;
      source_in = source_ff;
      if (cmd.accept) begin
         if (pos_ff == 16'd12 || pos_ff == 16'd13) begin
            ether_in = {ether_ff[7:0], req_packet_byte};
         end
         if (pos_ff == 16'd16 || pos_ff == 16'd17) begin
            length_in = {length_ff[7:0], req_packet_byte};
         end
         if (pos_ff >= 16'd26 && pos_ff <= 16'd29) begin
            source_in = {source_ff[23:0], req_packet_byte};
         end
         if (pos_ff != 16'hFFFF) begin
            pos_in = pos_ff + 16'd1;
         end
         if (req_last_byte) begin
            pos_in = '0;
            ether_in = '0;
            length_in = '0;
            source_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ether_ff <= '0;
         length_ff <= '0;
         source_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ether_ff <= ether_in;
         length_ff <= length_in;
         source_ff <= source_in;
      end
   end

   // Job registers hold the frame being looked up.
   always_ff @(posedge clock) begin
      if (cmd.load_job) begin
         job_key_ff <= source_ff;
         job_len_ff <= length_ff;
      end
   end

   // Scan index and fill count.
   always_comb begin
      idx_in = idx_ff;
      used_in = used_ff;
      if (cmd.load_job) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + COUNT_W'(1);
      end
      if (cmd.insert) begin
         used_in = used_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         used_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         used_ff <= used_in;
      end
   end

   // Table memories, addressed by the scan index.
   assign sum = cnt_rdata + {48'd0, job_len_ff};
   assign cnt_wdata = cmd.insert ? {48'd0, job_len_ff} : sum;

   ipv4sba_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (cmd.insert),
      .addr  (idx_ff[ADDR_W-1:0]),
      .wdata (job_key_ff),
      .rdata (key_rdata)
   );

   ipv4sba_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
      .clock (clock),
      .we    (cmd.insert | cmd.accumulate),
      .addr  (idx_ff[ADDR_W-1:0]),
      .wdata (cnt_wdata),
      .rdata (cnt_rdata)
   );

   // Status toward the controller.
   always_comb begin
      stat.frame_ok = (pos_ff >= LAST_SHORT_POS) && (ether_ff == ETHERTYPE_IPV4);
      stat.scan_end = (idx_ff == used_ff);
      stat.table_full = ({1'b0, used_ff} >= {1'b0, limit_ff})
         || (used_ff == COUNT_W'(TABLE_ENTRIES));
      stat.key_hit = (key_rdata == job_key_ff);
   end

   // Result registers, one beat per frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.report_skip | cmd.report_full | cmd.insert | cmd.accumulate;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.report_skip) begin
         acc_ff <= 1'b0;
         addr_out_ff <= '0;
         total_ff <= '0;
         fstat_ff <= STATUS_SKIPPED;
      end else if (cmd.report_full) begin
         acc_ff <= 1'b0;
         addr_out_ff <= job_key_ff;
         total_ff <= '0;
         fstat_ff <= STATUS_FULL;
      end else if (cmd.insert || cmd.accumulate) begin
         acc_ff <= 1'b1;
         addr_out_ff <= job_key_ff;
         total_ff <= cnt_wdata;
         fstat_ff <= STATUS_COUNTED;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_accounted = acc_ff;
   assign rsp_source_address = addr_out_ff;
   assign rsp_byte_total = total_ff;
   assign rsp_frame_status = fstat_ff;

`include "ipv4_source_byte_accounting_assert.svh"
   `SBA_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= COUNT_W'(TABLE_ENTRIES), "fill count past table size")
   `SBA_ASSERT_ALWAYS(a_insert_room, clock, reset, !cmd.insert || (!stat.table_full && stat.scan_end), "insert into full table")
   `SBA_ASSERT_ALWAYS(a_idx_range, clock, reset, !cmd.accumulate || (idx_ff < used_ff), "accumulate on unused entry")
endmodule

// File: sv/ipv4sba_ctrl.sv
// Controller: sequences the table scan for each counted frame.
`timescale 1ns / 1ps
module ipv4sba_ctrl
   import ipv4sba_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_last_byte,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);
   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_byte && stat.frame_ok) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (stat.scan_end) state_in = ST_IDLE;
            else state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (stat.key_hit) state_in = ST_ACCUM;
            else state_in = ST_LOOKUP;
         end
         ST_ACCUM: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands.
   always_comb begin
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.accept = accept;
            cmd.load_job = accept && req_last_byte && stat.frame_ok;
            cmd.report_skip = accept && req_last_byte && !stat.frame_ok;
         end
         ST_LOOKUP: begin
            cmd.report_full = stat.scan_end && stat.table_full;
            cmd.insert = stat.scan_end && !stat.table_full;
         end
         ST_COMPARE: begin
            cmd.step = !stat.key_hit;
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

`include "ipv4_source_byte_accounting_assert.svh"
   `SBA_ASSERT_NEXT(a_job_busy, clock, reset, cmd.load_job, busy, "lookup did not hold off input")
   `SBA_ASSERT_NEXT(a_accum_idle, clock, reset, cmd.accumulate, !busy, "no return to idle after update")
   `SBA_ASSERT_ALWAYS(a_one_cmd, clock, reset, $onehot0({cmd.report_skip, cmd.report_full, cmd.insert, cmd.accumulate}), "two reports at once")
endmodule

// File: sv/ipv4_source_byte_accounting.sv
// Top level of the per-source IPv4 byte accounting block.
// Frame bytes enter one beat per cycle on req_packet_byte with req_last_byte
// marking the final beat; a beat is taken when start is high and busy is low.
// One result beat per frame appears on the rsp_ ports for a single cycle,
// flagged by rsp_strobe; the receiver cannot stall it.
// Non-final bytes and frames that are short or not IPv4 do not raise busy;
// the report of a skipped frame appears in the cycle after its last byte.
// An IPv4 frame scans the source table one stored entry at a time, each in
// ST_LOOKUP and then ST_COMPARE, as the read of the key memory is registered.
// A new source is inserted, or a full table reported, in a final ST_LOOKUP,
// and a hit updates the counter in ST_ACCUM after its compare; busy stays high
// through the scan, and the result beat is on the outputs in the first cycle
// with busy low again.
// csr_entry_limit is written with csr_write_enable while the block is idle.
// Synchronous reset empties the table (fill count to zero), clears the
// capture state and sets the limit to 1000; no clearing pass is needed.
`timescale 1ns / 1ps
module ipv4_source_byte_accounting
   import ipv4sba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_packet_byte,
   input  logic               req_last_byte,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_entry_limit,
   output logic               rsp_strobe,
   output logic               rsp_accounted,
   output logic [31:0]        rsp_source_address,
   output logic [63:0]        rsp_byte_total,
   output logic [1:0]         rsp_frame_status
);
   cmd_type  cmd;
   stat_type stat;

   ipv4sba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_byte (req_last_byte),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   ipv4sba_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_packet_byte    (req_packet_byte),
      .req_last_byte      (req_last_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_entry_limit    (csr_entry_limit),
      .rsp_strobe         (rsp_strobe),
      .rsp_accounted      (rsp_accounted),
      .rsp_source_address (rsp_source_address),
      .rsp_byte_total     (rsp_byte_total),
      .rsp_frame_status   (rsp_frame_status)
   );
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the per-source IPv4 byte accounting block.
`timescale 1ns / 1ps
module testbench;
   import ipv4sba_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [7:0]         req_packet_byte;
   logic               req_last_byte;
   logic               csr_write_enable;
   logic [LIMIT_W-1:0] csr_entry_limit;
   logic               rsp_strobe;
   logic               rsp_accounted;
   logic [31:0]        rsp_source_address;
   logic [63:0]        rsp_byte_total;
   logic [1:0]         rsp_frame_status;

   ipv4_source_byte_accounting dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_packet_byte(req_packet_byte),
      .req_last_byte(req_last_byte),
      .csr_write_enable(csr_write_enable),
      .csr_entry_limit(csr_entry_limit),
      .rsp_strobe(rsp_strobe),
      .rsp_accounted(rsp_accounted),
      .rsp_source_address(rsp_source_address),
      .rsp_byte_total(rsp_byte_total),
      .rsp_frame_status(rsp_frame_status)
   );

   // One expected frame report.
   typedef struct {
      bit        accounted;
      bit [31:0] source;
      bit [63:0] total;
      bit [1:0]  status;
   } frame_report_type;

   // Byte accounting predictor and store of expected frame reports.
   class accounting_scoreboard;
      bit [15:0]        position;
      bit [15:0]        ether_type;
      bit [15:0]        total_length;
      bit [31:0]        source;
      bit [31:0]        keys [TABLE_ENTRIES];
      bit [63:0]        totals [TABLE_ENTRIES];
      int               used;
      bit [10:0]        limit;
      frame_report_type pending [$];
      int               mismatches;

      function new();
         position = 0; ether_type = 0; total_length = 0; source = 0;
         used = 0; limit = ENTRY_LIMIT_RESET; mismatches = 0;
      endfunction

      function void set_limit(bit [10:0] value);
         limit = value;
      endfunction

      // Capture header fields of one beat and predict a report on the last one.
      function void note_beat(bit [7:0] data, bit last);
         frame_report_type r;
         int slot;
         int cap;
         case (position)
            16'd12, 16'd13: ether_type = {ether_type[7:0], data};
            16'd16, 16'd17: total_length = {total_length[7:0], data};
            16'd26, 16'd27, 16'd28, 16'd29: source = {source[23:0], data};
            default: ;
         endcase
         if (position != 16'hFFFF) position++;
         if (!last) return;
         r = '{accounted: 0, source: 0, total: 0, status: STATUS_SKIPPED};
         if (position >= 34 && ether_type == ETHERTYPE_IPV4) begin
            r.source = source;
            slot = -1;
            for (int i = 0; i < used; i++)
               if (keys[i] == source) slot = i;
            cap = (int'(limit) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(limit);
            if (slot < 0 && used < cap) begin
               slot = used;
               keys[slot] = source;
               totals[slot] = 0;
               used++;
            end
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               totals[slot] += 64'(total_length);
               r.accounted = 1;
               r.total = totals[slot];
               r.status = STATUS_COUNTED;
            end
         end
         pending.push_back(r);
         position = 0; ether_type = 0; total_length = 0; source = 0;
      endfunction

      // Compare one report beat with the oldest expectation.
      function void check(bit acc, bit [31:0] src, bit [63:0] tot, bit [1:0] st);
         frame_report_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected report: acc %0d src %h total %0d status %0d",
                        acc, src, tot, st);
            return;
         end
         e = pending.pop_front();
         if (e.accounted !== acc || e.source !== src || e.total !== tot ||
             e.status !== st) begin
            mismatches++;
            if (mismatches <= 10)
               $display("report mismatch: expected acc %0d src %h total %0d status %0d, got acc %0d src %h total %0d status %0d",
                        e.accounted, e.source, e.total, e.status, acc, src, tot, st);
         end
      endfunction
   endclass

   accounting_scoreboard sb;
   int idle_cycles;
   int beats_sent;
   int frames_sent;
   bit [31:0] pool [8];

   // Clock generation.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Monitor accepted beats, register writes and report beats.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe)
            sb.check(rsp_accounted, rsp_source_address, rsp_byte_total, rsp_frame_status);
         if (csr_write_enable) sb.set_limit(csr_entry_limit);
         if (start && !busy) sb.note_beat(req_packet_byte, req_last_byte);
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Random gap length: mostly none, some short, a few long.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) return 0;
      if (pick < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Present one beat and hold it until the block takes it.
   task automatic send_beat(bit [7:0] data, bit last);
      int gap;
      start <= 1'b1;
      req_packet_byte <= data;
      req_last_byte <= last;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      beats_sent++;
      gap = gap_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap - 1) @(posedge clock);
         @(posedge clock);
      end
   endtask

   // Send a frame with the given header fields; other bytes are random.
   task automatic send_frame(bit [15:0] etype, bit [15:0] tlen, bit [31:0] src, int length);
      bit [7:0] data;
      for (int p = 0; p < length; p++) begin
         data = 8'($urandom_range(255));
         case (p)
            12: data = etype[15:8];
            13: data = etype[7:0];
            16: data = tlen[15:8];
            17: data = tlen[7:0];
            26: data = src[31:24];
            27: data = src[23:16];
            28: data = src[15:8];
            29: data = src[7:0];
            default: ;
         endcase
         send_beat(data, p == length - 1);
      end
      frames_sent++;
   endtask

   // Let every report drain, then write the limit with the block idle.
   task automatic write_limit(bit [10:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_entry_limit <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_entry_limit <= 11'($urandom_range(2047));
   endtask

   // One random frame: mostly well-formed IPv4, the rest noise.
   task automatic random_frame();
      int pick;
      bit [31:0] src;
      pick = $urandom_range(99);
      src = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(7)];
      if (pick < 75)
         send_frame(ETHERTYPE_IPV4, 16'($urandom_range(16'hFFFF)), src,
                    $urandom_range(46, 34));
      else if (pick < 85)
         send_frame(ETHERTYPE_IPV4, 16'($urandom_range(16'hFFFF)), src,
                    $urandom_range(33, 1));
      else if (pick < 92)
         send_frame(16'h86DD, 16'($urandom_range(16'hFFFF)), src, $urandom_range(60, 34));
      else
         send_frame(16'($urandom_range(16'hFFFF)), 16'($urandom), $urandom,
                    $urandom_range(50, 1));
   endtask

   initial begin
      bit [10:0] limits [7];
      sb = new();
      beats_sent = 0;
      frames_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_packet_byte = '0;
      req_last_byte = 1'b0;
      csr_write_enable = 1'b0;
      csr_entry_limit = '0;
      foreach (pool[i]) pool[i] = $urandom;
      pool[0] = 32'h0000_0000;
      pool[1] = 32'hFFFF_FFFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: extremes, short, IPv6, repeat hits, long frame.
      send_frame(ETHERTYPE_IPV4, 16'hFFFF, 32'hFFFF_FFFF, 34);
      send_frame(ETHERTYPE_IPV4, 16'h0000, 32'h0000_0000, 34);
      send_frame(ETHERTYPE_IPV4, 16'hFFFF, 32'hFFFF_FFFF, 40);
      send_frame(ETHERTYPE_IPV4, 16'h1234, 32'hC0A8_0001, 33);
      send_frame(16'h86DD, 16'h0100, 32'hC0A8_0001, 60);
      send_frame(16'h0000, 16'h0100, 32'h0A00_0001, 34);
      send_frame(ETHERTYPE_IPV4, 16'h0040, 32'hC0A8_0001, 1);
      send_frame(ETHERTYPE_IPV4, 16'h05DC, 32'hC0A8_0001, 100);
      send_frame(ETHERTYPE_IPV4, 16'h05DC, 32'hC0A8_0001, 34);

      // Table full: limit at three entries already used, then zero.
      write_limit(11'd3);
      send_frame(ETHERTYPE_IPV4, 16'h0010, 32'h0A0B_0C0D, 34);
      send_frame(ETHERTYPE_IPV4, 16'h0010, 32'hC0A8_0001, 34);
      write_limit(11'd0);
      send_frame(ETHERTYPE_IPV4, 16'h0010, 32'h0102_0304, 34);
      send_frame(ETHERTYPE_IPV4, 16'h0020, 32'h0000_0000, 34);

      // Random phases over several limits.
      limits = '{11'd6, 11'd1, 11'd2047, 11'd0, 11'd1024, 11'd9, 11'd1000};
      foreach (limits[k]) begin
         write_limit(limits[k]);
         for (int n = 0; n < 4; n++) random_frame();
      end
      while (beats_sent < 1550 || frames_sent < 40) random_frame();

      // Drain and finish.
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
